FILE: hw/rtl/spr_pkg.sv
package spr_pkg;

    // action codes of a request beat
    localparam logic [2:0] ACT_INIT = 3'd0;
    localparam logic [2:0] ACT_INS  = 3'd1;
    localparam logic [2:0] ACT_DATA = 3'd2;
    localparam logic [2:0] ACT_GET  = 3'd3;
    localparam logic [2:0] ACT_DEL  = 3'd4;
    localparam logic [2:0] ACT_READ = 3'd5;

    // response status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_NOREC = 2'd2;
    localparam logic [1:0] ST_IGN   = 2'd3;

    // command queue between front and back
    localparam int CQ_DEPTH = 2;
    localparam int CQ_PW    = 1;
    localparam int CQ_CW    = 2;

    typedef struct packed {
        logic [2:0]  action;
        logic [12:0] record_size;
        logic [7:0]  data_byte;
        logic [9:0]  slot_index;
        logic [11:0] byte_address;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  assigned_slot;
        logic [11:0] found_offset;
        logic [12:0] found_size;
        logic [7:0]  read_value;
    } rsp_t;

    typedef enum logic [2:0] {
        OP_INIT,
        OP_INS,
        OP_DATA,
        OP_GET,
        OP_DEL,
        OP_READ,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t  op;
        req_t req;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cq_head_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_READ_WAIT,
        B_GET_WAIT,
        B_SCR,
        B_CMP_RD,
        B_CMP_WAIT,
        B_MOVE,
        B_CHECK,
        B_SRCH_RD,
        B_SRCH_WAIT,
        B_COMMIT
    } bstate_t;

endpackage

FILE: hw/rtl/slotted_page_record_store.sv
// A beat reaches rsp through the command queue and the response register for init, delete,
// insert data, ignored actions and get of an unused index; get and read byte add a memory read.
// Insert start reads the slot entries one at a time before it commits a slot; when free space
// runs short it first copies the page to scratch, then walks the slots and moves each live record.
// Throughput: one beat per cycle for simple actions while rsp is not stalled.
// Reset clears the counters and the queue; page and slot memories keep no reset.
module slotted_page_record_store #(
    parameter int PAGE_BYTES   = 4096,
    parameter int HEADER_BYTES = 8,
    parameter int SLOT_BYTES   = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  spr_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output spr_pkg::rsp_t rsp
);

    logic              push, pop, q_full;
    spr_pkg::cmd_t     cmd;
    spr_pkg::cq_head_t head;

    // classify incoming beats
    spr_front #(.PAGE_BYTES(PAGE_BYTES)) u_front (
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .q_full(q_full), .push(push), .cmd(cmd)
    );

    // short queue between front and back
    spr_cmd_fifo u_fifo (
        .clk(clk), .rst_n(rst_n), .push(push), .cmd(cmd), .full(q_full),
        .pop(pop), .head(head)
    );

    // execute commands against the page
    spr_back #(
        .PAGE_BYTES(PAGE_BYTES), .HEADER_BYTES(HEADER_BYTES), .SLOT_BYTES(SLOT_BYTES)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .head(head), .pop(pop),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    // back never pops an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop from empty command queue");

    // back never pops while a response is held
    a_pop_rsp_free: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !(rsp_valid && rsp_stall))
        else $error("pop while response held");

    // a taken beat leaves the queue non-empty
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> head.valid)
        else $error("accepted beat lost");

endmodule

FILE: hw/rtl/spr_ram.sv
module spr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/spr_front.sv
module spr_front #(
    parameter int PAGE_BYTES = 4096
) (
    input  logic          req_valid,
    output logic          req_stall,
    input  spr_pkg::req_t req,
    input  logic          q_full,
    output logic          push,
    output spr_pkg::cmd_t cmd
);

    // classify the request beat
    always_comb
    begin
        cmd.req = req;
        unique case (req.action)
            spr_pkg::ACT_INIT: cmd.op = spr_pkg::OP_INIT;
            spr_pkg::ACT_INS:  cmd.op = spr_pkg::OP_INS;
            spr_pkg::ACT_DATA: cmd.op = spr_pkg::OP_DATA;
            spr_pkg::ACT_GET:  cmd.op = spr_pkg::OP_GET;
            spr_pkg::ACT_DEL:  cmd.op = spr_pkg::OP_DEL;
            spr_pkg::ACT_READ:
            begin
                if (32'(req.byte_address) < 32'(PAGE_BYTES))
                begin
                    cmd.op = spr_pkg::OP_READ;
                end
                else
                begin
                    cmd.op = spr_pkg::OP_NONE;
                end
            end
            default:           cmd.op = spr_pkg::OP_NONE;
        endcase
    end

    // push into the queue while it has room
    assign req_stall = q_full;
    assign push      = req_valid && !q_full;

endmodule

FILE: hw/rtl/spr_cmd_fifo.sv
module spr_cmd_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  spr_pkg::cmd_t     cmd,
    output logic              full,
    input  logic              pop,
    output spr_pkg::cq_head_t head
);

    spr_pkg::cmd_t            entry_reg [spr_pkg::CQ_DEPTH];
    logic [spr_pkg::CQ_PW-1:0] wptr_reg, wptr_next;
    logic [spr_pkg::CQ_PW-1:0] rptr_reg, rptr_next;
    logic [spr_pkg::CQ_CW-1:0] count_reg, count_next;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= cmd;
        end
    end

    // pointers and fill level
    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = wptr_reg + spr_pkg::CQ_PW'(1);
        end
        if (pop)
        begin
            rptr_next = rptr_reg + spr_pkg::CQ_PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + spr_pkg::CQ_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - spr_pkg::CQ_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    assign full       = (count_reg == spr_pkg::CQ_CW'(spr_pkg::CQ_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = entry_reg[rptr_reg];

endmodule

FILE: hw/rtl/spr_back.sv
module spr_back #(
    parameter int PAGE_BYTES   = 4096,
    parameter int HEADER_BYTES = 8,
    parameter int SLOT_BYTES   = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  spr_pkg::cq_head_t head,
    output logic              pop,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output spr_pkg::rsp_t     rsp
);

    localparam int SLOT_CAP = (PAGE_BYTES - HEADER_BYTES) / SLOT_BYTES;
    localparam int AW       = $clog2(PAGE_BYTES);
    localparam int CW       = $clog2(PAGE_BYTES + 1);
    localparam int SIW      = $clog2(SLOT_CAP);
    localparam int SCW      = $clog2(SLOT_CAP + 1);

    spr_pkg::bstate_t state_reg, state_next;
    spr_pkg::req_t    cmd_reg, cmd_next;
    logic [SCW-1:0]   slots_used_reg, slots_used_next;
    logic [CW-1:0]    free_low_reg, free_low_next;
    logic [CW-1:0]    free_high_reg, free_high_next;
    logic [CW-1:0]    fill_ptr_reg, fill_ptr_next;
    logic [CW-1:0]    fill_rem_reg, fill_rem_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [SCW-1:0]   i_reg, i_next;
    logic [CW-1:0]    cur_reg, cur_next;
    logic [CW-1:0]    from_reg, from_next;
    logic [CW-1:0]    sz_reg, sz_next;
    logic [SIW-1:0]   tgt_reg, tgt_next;
    logic             rsp_valid_reg, rsp_valid_next;
    spr_pkg::rsp_t    rsp_reg, rsp_next;

    // memory ports
    logic            page_we, scr_we, off_we, size_we;
    logic [AW-1:0]   page_waddr, page_raddr, scr_waddr, scr_raddr;
    logic [7:0]      page_wdata, page_rdata, scr_rdata;
    logic [SIW-1:0]  slot_waddr_off, slot_waddr_size, slot_raddr;
    logic [CW-1:0]   off_wdata, size_wdata, off_rdata, size_rdata;

    logic            rsp_load;
    spr_pkg::rsp_t   res;
    logic [CW:0]     src_sum, dst_sum;

    spr_ram #(.WIDTH(8), .DEPTH(PAGE_BYTES)) u_page_ram (
        .clk(clk), .we(page_we), .waddr(page_waddr), .wdata(page_wdata),
        .raddr(page_raddr), .rdata(page_rdata)
    );

    spr_ram #(.WIDTH(8), .DEPTH(PAGE_BYTES)) u_scr_ram (
        .clk(clk), .we(scr_we), .waddr(scr_waddr), .wdata(page_rdata),
        .raddr(scr_raddr), .rdata(scr_rdata)
    );

    spr_ram #(.WIDTH(CW), .DEPTH(SLOT_CAP)) u_off_ram (
        .clk(clk), .we(off_we), .waddr(slot_waddr_off), .wdata(off_wdata),
        .raddr(slot_raddr), .rdata(off_rdata)
    );

    spr_ram #(.WIDTH(CW), .DEPTH(SLOT_CAP)) u_size_ram (
        .clk(clk), .we(size_we), .waddr(slot_waddr_size), .wdata(size_wdata),
        .raddr(slot_raddr), .rdata(size_rdata)
    );

    // free space check: record plus one slot entry
    function automatic logic room_ok(input logic [CW-1:0] hi, input logic [CW-1:0] lo,
                                     input logic [12:0] size);
        logic [31:0] need;
        need = 32'(size) + 32'(SLOT_BYTES);
        return (hi >= lo) && ((32'(hi) - 32'(lo)) >= need);
    endfunction

    // sequencer for the classified commands
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        slots_used_next = slots_used_reg;
        free_low_next   = free_low_reg;
        free_high_next  = free_high_reg;
        fill_ptr_next   = fill_ptr_reg;
        fill_rem_next   = fill_rem_reg;
        cnt_next        = cnt_reg;
        i_next          = i_reg;
        cur_next        = cur_reg;
        from_next       = from_reg;
        sz_next         = sz_reg;
        tgt_next        = tgt_reg;
        pop             = 1'b0;
        rsp_load        = 1'b0;
        res             = '0;
        page_we         = 1'b0;
        page_waddr      = fill_ptr_reg[AW-1:0];
        page_wdata      = head.cmd.req.data_byte;
        page_raddr      = AW'(head.cmd.req.byte_address);
        scr_we          = 1'b0;
        scr_waddr       = AW'(cnt_reg - CW'(1));
        scr_raddr       = AW'(from_reg + cnt_reg);
        off_we          = 1'b0;
        size_we         = 1'b0;
        slot_waddr_off  = i_reg[SIW-1:0];
        slot_waddr_size = SIW'(head.cmd.req.slot_index);
        off_wdata       = cur_reg;
        size_wdata      = '0;
        slot_raddr      = SIW'(head.cmd.req.slot_index);
        src_sum         = (CW+1)'(from_reg) + (CW+1)'(cnt_reg) - (CW+1)'(1);
        dst_sum         = (CW+1)'(cur_reg) + (CW+1)'(cnt_reg) - (CW+1)'(1);

        unique case (state_reg)
            spr_pkg::B_IDLE:
            begin
                if (head.valid && (!rsp_valid_reg || !rsp_stall))
                begin
                    pop      = 1'b1;
                    cmd_next = head.cmd.req;
                    unique case (head.cmd.op)
                        spr_pkg::OP_INIT:
                        begin
                            slots_used_next = '0;
                            free_low_next   = CW'(HEADER_BYTES);
                            free_high_next  = CW'(PAGE_BYTES);
                            fill_ptr_next   = '0;
                            fill_rem_next   = '0;
                            rsp_load        = 1'b1;
                            res.status      = spr_pkg::ST_OK;
                        end
                        spr_pkg::OP_INS:
                        begin
                            fill_ptr_next = '0;
                            fill_rem_next = '0;
                            i_next        = '0;
                            cnt_next      = '0;
                            if (room_ok(free_high_reg, free_low_reg,
                                        head.cmd.req.record_size))
                            begin
                                state_next = spr_pkg::B_SRCH_RD;
                            end
                            else
                            begin
                                state_next = spr_pkg::B_SCR;
                            end
                        end
                        spr_pkg::OP_DATA:
                        begin
                            rsp_load = 1'b1;
                            if (fill_rem_reg != '0)
                            begin
                                page_we       = (32'(fill_ptr_reg) < 32'(PAGE_BYTES));
                                fill_ptr_next = fill_ptr_reg + CW'(1);
                                fill_rem_next = fill_rem_reg - CW'(1);
                                res.status    = spr_pkg::ST_OK;
                            end
                            else
                            begin
                                res.status = spr_pkg::ST_IGN;
                            end
                        end
                        spr_pkg::OP_GET:
                        begin
                            if (32'(head.cmd.req.slot_index) < 32'(slots_used_reg))
                            begin
                                state_next = spr_pkg::B_GET_WAIT;
                            end
                            else
                            begin
                                rsp_load   = 1'b1;
                                res.status = spr_pkg::ST_NOREC;
                            end
                        end
                        spr_pkg::OP_DEL:
                        begin
                            rsp_load = 1'b1;
                            if (32'(head.cmd.req.slot_index) < 32'(slots_used_reg))
                            begin
                                size_we    = 1'b1;
                                res.status = spr_pkg::ST_OK;
                            end
                            else
                            begin
                                res.status = spr_pkg::ST_NOREC;
                            end
                        end
                        spr_pkg::OP_READ:
                        begin
                            state_next = spr_pkg::B_READ_WAIT;
                        end
                        default:
                        begin
                            rsp_load   = 1'b1;
                            res.status = spr_pkg::ST_IGN;
                        end
                    endcase
                end
            end

            spr_pkg::B_READ_WAIT:
            begin
                rsp_load       = 1'b1;
                res.status     = spr_pkg::ST_OK;
                res.read_value = page_rdata;
                state_next     = spr_pkg::B_IDLE;
            end

            spr_pkg::B_GET_WAIT:
            begin
                rsp_load   = 1'b1;
                state_next = spr_pkg::B_IDLE;
                if (size_rdata != '0)
                begin
                    res.status       = spr_pkg::ST_OK;
                    res.found_offset = 12'(off_rdata);
                    res.found_size   = 13'(size_rdata);
                end
                else
                begin
                    res.status = spr_pkg::ST_NOREC;
                end
            end

            // copy the whole page into scratch, one byte per cycle
            spr_pkg::B_SCR:
            begin
                page_raddr = cnt_reg[AW-1:0];
                scr_we     = (cnt_reg != '0);
                if (cnt_reg == CW'(PAGE_BYTES))
                begin
                    i_next     = '0;
                    cur_next   = CW'(HEADER_BYTES);
                    state_next = spr_pkg::B_CMP_RD;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end

            // walk the slots in order
            spr_pkg::B_CMP_RD:
            begin
                slot_raddr = i_reg[SIW-1:0];
                if (i_reg >= slots_used_reg)
                begin
                    free_low_next = cur_reg;
                    state_next    = spr_pkg::B_CHECK;
                end
                else
                begin
                    state_next = spr_pkg::B_CMP_WAIT;
                end
            end

            spr_pkg::B_CMP_WAIT:
            begin
                if (size_rdata == '0)
                begin
                    i_next     = i_reg + SCW'(1);
                    state_next = spr_pkg::B_CMP_RD;
                end
                else
                begin
                    off_we     = 1'b1;
                    from_next  = off_rdata;
                    sz_next    = size_rdata;
                    cnt_next   = '0;
                    state_next = spr_pkg::B_MOVE;
                end
            end

            // move one live record down from scratch
            spr_pkg::B_MOVE:
            begin
                page_waddr = dst_sum[AW-1:0];
                page_wdata = scr_rdata;
                page_we    = (cnt_reg != '0)
                             && (src_sum < (CW+1)'(PAGE_BYTES))
                             && (dst_sum < (CW+1)'(PAGE_BYTES));
                if (cnt_reg == sz_reg)
                begin
                    cur_next   = cur_reg + sz_reg;
                    i_next     = i_reg + SCW'(1);
                    state_next = spr_pkg::B_CMP_RD;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end

            spr_pkg::B_CHECK:
            begin
                i_next = '0;
                if (room_ok(free_high_reg, free_low_reg, cmd_reg.record_size))
                begin
                    state_next = spr_pkg::B_SRCH_RD;
                end
                else
                begin
                    rsp_load   = 1'b1;
                    res.status = spr_pkg::ST_FULL;
                    state_next = spr_pkg::B_IDLE;
                end
            end

            // first deleted slot, else append
            spr_pkg::B_SRCH_RD:
            begin
                slot_raddr = i_reg[SIW-1:0];
                if (i_reg >= slots_used_reg)
                begin
                    if (32'(slots_used_reg) >= 32'(SLOT_CAP))
                    begin
                        rsp_load   = 1'b1;
                        res.status = spr_pkg::ST_FULL;
                        state_next = spr_pkg::B_IDLE;
                    end
                    else
                    begin
                        tgt_next        = slots_used_reg[SIW-1:0];
                        slots_used_next = slots_used_reg + SCW'(1);
                        free_high_next  = free_high_reg - CW'(SLOT_BYTES);
                        state_next      = spr_pkg::B_COMMIT;
                    end
                end
                else
                begin
                    state_next = spr_pkg::B_SRCH_WAIT;
                end
            end

            spr_pkg::B_SRCH_WAIT:
            begin
                if (size_rdata == '0)
                begin
                    tgt_next   = i_reg[SIW-1:0];
                    state_next = spr_pkg::B_COMMIT;
                end
                else
                begin
                    i_next     = i_reg + SCW'(1);
                    state_next = spr_pkg::B_SRCH_RD;
                end
            end

            spr_pkg::B_COMMIT:
            begin
                off_we            = 1'b1;
                size_we           = 1'b1;
                slot_waddr_off    = tgt_reg;
                slot_waddr_size   = tgt_reg;
                off_wdata         = free_low_reg;
                size_wdata        = CW'(cmd_reg.record_size);
                fill_ptr_next     = free_low_reg;
                fill_rem_next     = CW'(cmd_reg.record_size);
                free_low_next     = free_low_reg + CW'(cmd_reg.record_size);
                rsp_load          = 1'b1;
                res.status        = spr_pkg::ST_OK;
                res.assigned_slot = 10'(tgt_reg);
                state_next        = spr_pkg::B_IDLE;
            end

            default:
            begin
                state_next = spr_pkg::B_IDLE;
            end
        endcase

        // response register
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = res;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= spr_pkg::B_IDLE;
            slots_used_reg <= '0;
            free_low_reg   <= CW'(HEADER_BYTES);
            free_high_reg  <= CW'(PAGE_BYTES);
            fill_ptr_reg   <= '0;
            fill_rem_reg   <= '0;
            cnt_reg        <= '0;
            i_reg          <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            slots_used_reg <= slots_used_next;
            free_low_reg   <= free_low_next;
            free_high_reg  <= free_high_next;
            fill_ptr_reg   <= fill_ptr_next;
            fill_rem_reg   <= fill_rem_next;
            cnt_reg        <= cnt_next;
            i_reg          <= i_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        cur_reg  <= cur_next;
        from_reg <= from_next;
        sz_reg   <= sz_next;
        tgt_reg  <= tgt_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int PAGE_BYTES   = 4096;
    localparam int HEADER_BYTES = 8;
    localparam int SLOT_BYTES   = 4;
    localparam int SLOT_CAP     = (PAGE_BYTES - HEADER_BYTES) / SLOT_BYTES;

    // idling modes
    localparam int MODE_NONE = 0;
    localparam int MODE_SEND = 1;
    localparam int MODE_RECV = 2;
    localparam int MODE_BOTH = 3;

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_stall;
    spr_pkg::req_t req;
    logic          rsp_valid;
    logic          rsp_stall;
    spr_pkg::rsp_t rsp;
    logic          req_fire;

    slotted_page_record_store u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // page mirror
    logic [7:0]  page_mem [PAGE_BYTES];
    logic        page_written [PAGE_BYTES];
    logic [7:0]  scratch_mem [PAGE_BYTES];
    logic [11:0] slot_off [SLOT_CAP];
    logic [12:0] slot_len [SLOT_CAP];
    int unsigned n_slots;
    int unsigned lo_mark;
    int unsigned hi_mark;
    int unsigned fill_ptr;
    int unsigned fill_left;

    spr_pkg::req_t pending_reqs [$];
    spr_pkg::rsp_t expected_rsps [$];
    int   idle_mode;
    int   hold_cycles;
    int   errors;
    int   mismatches;
    int   rsp_count;
    int   full_count;
    int   compact_count;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // relocate live records toward the header in slot order
    task automatic compact_records();
        int unsigned cur;
        int unsigned s;
        int unsigned d;
        cur = HEADER_BYTES;
        compact_count++;
        scratch_mem = page_mem;
        for (int i = 0; i < n_slots && i < SLOT_CAP; i++)
        begin
            if (slot_len[i] != 0)
            begin
                for (int k = 0; k < slot_len[i]; k++)
                begin
                    s = slot_off[i] + k;
                    d = cur + k;
                    if (s < PAGE_BYTES && d < PAGE_BYTES)
                        page_mem[d] = scratch_mem[s];
                end
                slot_off[i] = cur[11:0];
                cur += slot_len[i];
            end
        end
        lo_mark = cur;
    endtask

    function automatic bit has_room(int unsigned need);
        return hi_mark >= lo_mark && hi_mark - lo_mark >= need;
    endfunction

    // compute the response for one accepted request beat
    task automatic predict_page_rsp(input spr_pkg::req_t r, output spr_pkg::rsp_t e);
        int unsigned need;
        int unsigned target;
        e = '0;
        e.status = spr_pkg::ST_IGN;
        unique case (r.action)
            spr_pkg::ACT_INIT:
            begin
                n_slots = 0;
                lo_mark = HEADER_BYTES;
                hi_mark = PAGE_BYTES;
                fill_ptr = 0;
                fill_left = 0;
                e.status = spr_pkg::ST_OK;
            end
            spr_pkg::ACT_INS:
            begin
                need = r.record_size + SLOT_BYTES;
                target = n_slots;
                fill_ptr = 0;
                fill_left = 0;
                if (!has_room(need))
                    compact_records();
                if (!has_room(need))
                begin
                    e.status = spr_pkg::ST_FULL;
                    full_count++;
                end
                else
                begin
                    for (int i = 0; i < n_slots && i < SLOT_CAP; i++)
                    begin
                        if (slot_len[i] == 0 && target == n_slots)
                            target = i;
                    end
                    if (target == n_slots && n_slots >= SLOT_CAP)
                    begin
                        e.status = spr_pkg::ST_FULL;
                        full_count++;
                    end
                    else
                    begin
                        if (target == n_slots)
                        begin
                            n_slots++;
                            hi_mark -= SLOT_BYTES;
                        end
                        slot_off[target] = lo_mark[11:0];
                        slot_len[target] = r.record_size;
                        fill_ptr = lo_mark;
                        fill_left = r.record_size;
                        lo_mark += r.record_size;
                        e.assigned_slot = target[9:0];
                        e.status = spr_pkg::ST_OK;
                    end
                end
            end
            spr_pkg::ACT_DATA:
            begin
                if (fill_left != 0)
                begin
                    if (fill_ptr < PAGE_BYTES)
                    begin
                        page_mem[fill_ptr] = r.data_byte;
                        page_written[fill_ptr] = 1'b1;
                    end
                    fill_ptr++;
                    fill_left--;
                    e.status = spr_pkg::ST_OK;
                end
            end
            spr_pkg::ACT_GET:
            begin
                if (r.slot_index < n_slots && slot_len[r.slot_index] != 0)
                begin
                    e.found_offset = slot_off[r.slot_index];
                    e.found_size = slot_len[r.slot_index];
                    e.status = spr_pkg::ST_OK;
                end
                else
                    e.status = spr_pkg::ST_NOREC;
            end
            spr_pkg::ACT_DEL:
            begin
                if (r.slot_index < n_slots)
                begin
                    slot_len[r.slot_index] = '0;
                    e.status = spr_pkg::ST_OK;
                end
                else
                    e.status = spr_pkg::ST_NOREC;
            end
            spr_pkg::ACT_READ:
            begin
                e.read_value = page_mem[r.byte_address];
                e.status = spr_pkg::ST_OK;
            end
            default: ;
        endcase
    endtask

    // request beat taken at the last rising edge
    always @(posedge clk)
    begin
        req_fire <= rst_n && req_valid && !req_stall;
    end

    // request driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_valid || req_fire)
            begin
                if (pending_reqs.size() > 0 &&
                    !((idle_mode == MODE_SEND || idle_mode == MODE_BOTH) &&
                      $urandom_range(99) < 85))
                begin
                    req <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                end
                else
                begin
                    req_valid <= 1'b0;
                    req <= '0;
                end
            end
        end
    end

    // receiver stall, with a long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= (idle_mode == MODE_RECV || idle_mode == MODE_BOTH) &&
                         $urandom_range(99) < 85;
    end

    // accepted beats: predict on the request side, compare on the response side
    always @(posedge clk)
    begin
        spr_pkg::rsp_t e;
        spr_pkg::rsp_t act;
        if (rst_n && req_valid && !req_stall)
        begin
            predict_page_rsp(req, e);
            expected_rsps.push_back(e);
        end
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            act = rsp;
            rsp_count++;
            if (expected_rsps.size() == 0)
            begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response beat %p", act);
            end
            else
            begin
                e = expected_rsps.pop_front();
                if (act.status !== e.status || act.assigned_slot !== e.assigned_slot ||
                    act.found_offset !== e.found_offset ||
                    act.found_size !== e.found_size || act.read_value !== e.read_value)
                begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", e, act);
                end
            end
        end
    end

    function automatic spr_pkg::req_t make_req(logic [2:0] a, int unsigned sz,
                                               int unsigned b, int unsigned idx,
                                               int unsigned addr);
        spr_pkg::req_t r;
        r.action = a;
        r.record_size = sz[12:0];
        r.data_byte = b[7:0];
        r.slot_index = idx[9:0];
        r.byte_address = addr[11:0];
        return r;
    endfunction

    // queue an insert plus all of its data bytes
    task automatic queue_record(int unsigned sz);
        pending_reqs.push_back(make_req(spr_pkg::ACT_INS, sz, $urandom, $urandom, $urandom));
        for (int k = 0; k < sz; k++)
            pending_reqs.push_back(make_req(spr_pkg::ACT_DATA, $urandom, $urandom_range(255),
                                            $urandom, $urandom));
    endtask

    task automatic queue_init();
        pending_reqs.push_back(make_req(spr_pkg::ACT_INIT, $urandom, $urandom, $urandom,
                                        $urandom));
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req_valid)
            @(posedge clk);
    endtask

    // reserve a big block and free it at once, so free space runs short and compacts
    task automatic queue_reservation();
        int unsigned slot;
        wait_drained();
        slot = n_slots;
        for (int i = 0; i < n_slots; i++)
        begin
            if (slot_len[i] == 0 && slot == n_slots)
                slot = i;
        end
        pending_reqs.push_back(make_req(spr_pkg::ACT_INS, $urandom_range(1800, 3000),
                                        0, 0, 0));
        pending_reqs.push_back(make_req(spr_pkg::ACT_DEL, 0, 0, slot, 0));
    endtask

    // read address among bytes already written, else the first byte after the header
    function automatic int unsigned pick_read_addr();
        int unsigned a;
        for (int t = 0; t < 64; t++)
        begin
            a = $urandom_range(PAGE_BYTES - 1);
            if (page_written[a])
                return a;
        end
        return HEADER_BYTES;
    endfunction

    initial
    begin
        int unsigned r;
        int unsigned sz;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_stall = 1'b0;
        idle_mode = MODE_NONE;
        hold_cycles = 0;
        errors = 0;
        mismatches = 0;
        rsp_count = 0;
        full_count = 0;
        compact_count = 0;
        n_slots = 0;
        lo_mark = HEADER_BYTES;
        hi_mark = PAGE_BYTES;
        fill_ptr = 0;
        fill_left = 0;
        for (int i = 0; i < PAGE_BYTES; i++)
        begin
            page_mem[i] = '0;
            page_written[i] = 1'b0;
        end
        for (int i = 0; i < SLOT_CAP; i++)
        begin
            slot_off[i] = '0;
            slot_len[i] = '0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: edge fields, each action, the special cases
        pending_reqs.push_back(make_req(spr_pkg::ACT_DATA, 0, 8'hff, 0, 0));
        pending_reqs.push_back(make_req(spr_pkg::ACT_GET, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(spr_pkg::ACT_DEL, 0, 0, 1023, 0));
        pending_reqs.push_back(make_req(3'd6, 8191, 255, 1023, 4095));
        pending_reqs.push_back(make_req(3'd7, 0, 0, 0, 0));
        queue_record(3);
        pending_reqs.push_back(make_req(spr_pkg::ACT_INS, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(spr_pkg::ACT_INS, 2, 0, 0, 0));
        pending_reqs.push_back(make_req(spr_pkg::ACT_DATA, 0, 8'h00, 0, 0));
        pending_reqs.push_back(make_req(spr_pkg::ACT_INS, 1, 0, 0, 0));
        pending_reqs.push_back(make_req(spr_pkg::ACT_DATA, 0, 8'haa, 0, 0));
        pending_reqs.push_back(make_req(spr_pkg::ACT_GET, 0, 0, 3, 0));
        pending_reqs.push_back(make_req(spr_pkg::ACT_GET, 0, 0, 1, 0));
        pending_reqs.push_back(make_req(spr_pkg::ACT_DEL, 0, 0, 1, 0));
        pending_reqs.push_back(make_req(spr_pkg::ACT_DEL, 0, 0, 1, 0));
        pending_reqs.push_back(make_req(spr_pkg::ACT_GET, 0, 0, 1, 0));
        pending_reqs.push_back(make_req(spr_pkg::ACT_INS, 8191, 0, 0, 0));
        pending_reqs.push_back(make_req(spr_pkg::ACT_INS, 4096, 0, 0, 0));
        pending_reqs.push_back(make_req(spr_pkg::ACT_READ, 0, 0, 0, 8));
        pending_reqs.push_back(make_req(spr_pkg::ACT_READ, 0, 0, 0, 10));
        queue_init();
        wait_drained();
        repeat (20) @(posedge clk);

        // random phases, one per idling mode
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_mode = ph;
            for (int n = 0; n < 90; )
            begin
                r = $urandom_range(99);
                if (r < 38)
                begin
                    sz = $urandom_range(0, 12);
                    queue_record(sz);
                    n += sz;
                end
                else if (r < 44)
                begin
                    // big reservations push free space down and force compaction
                    queue_reservation();
                    n += 1;
                end
                else if (r < 58)
                    pending_reqs.push_back(make_req(spr_pkg::ACT_DEL, 0, 0,
                                                    $urandom_range(0, 12), 0));
                else if (r < 72)
                    pending_reqs.push_back(make_req(spr_pkg::ACT_GET, 0, 0,
                                                    $urandom_range(0, 14), 0));
                else if (r < 86)
                    pending_reqs.push_back(make_req(spr_pkg::ACT_READ, 0, 0, 0,
                                                    pick_read_addr()));
                else if (r < 90)
                    pending_reqs.push_back(make_req(spr_pkg::ACT_DATA, 0, $urandom, 0, 0));
                else if (r < 93)
                    pending_reqs.push_back(make_req(3'($urandom_range(6, 7)), $urandom,
                                                    $urandom, $urandom, $urandom));
                else if (r < 96)
                    pending_reqs.push_back(make_req(spr_pkg::ACT_GET, 0, 0, $urandom, 0));
                else
                    queue_init();
                n++;
                // keep the queue short so reads see bytes already written
                if (pending_reqs.size() > 40)
                    wait_drained();
            end
            if (ph == 0)
            begin
                // long receiver hold-off while the sender keeps offering
                hold_cycles = 400;
                for (int k = 0; k < 30; k++)
                    pending_reqs.push_back(make_req(spr_pkg::ACT_GET, 0, 0, k % 8, 0));
            end
            // sender pauses until every result is in
            wait_drained();
            repeat (20) @(posedge clk);
        end

        // a run of small records, to walk the directory scan
        idle_mode = MODE_NONE;
        for (int k = 0; k < 10; k++)
            queue_record($urandom_range(0, 3));
        wait_drained();
        repeat (20) @(posedge clk);

        $display("covered %0d responses, %0d full inserts, %0d compactions",
                 rsp_count, full_count, compact_count);
        $display("all request actions under four idling modes and a long hold-off");
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // run limit
    initial
    begin
        #50ms;
        $display("status: fail");
        $finish;
    end

endmodule
